@@ rtl/tom_pkg.sv @@
// Package for the 2-opt tour move engine.
// Sizes, sequencer state type and saturation helpers; no dependencies.
package tom_pkg;

    localparam int MAX_CITIES_DEF = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int DELTA_W  = 27;
    localparam int ENERGY_W = 40;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_PROPOSE = 2'd1;
    localparam logic [1:0] MODE_APPLY   = 2'd2;
    localparam logic [1:0] MODE_TOUR    = 2'd3;

    localparam logic signed [63:0] DELTA_MAX  = (64'sd1 <<< (DELTA_W - 1)) - 64'sd1;
    localparam logic signed [63:0] DELTA_MIN  = -DELTA_MAX - 64'sd1;
    localparam logic signed [63:0] ENERGY_MAX = (64'sd1 <<< (ENERGY_W - 1)) - 64'sd1;
    localparam logic signed [63:0] ENERGY_MIN = -ENERGY_MAX - 64'sd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_PRD,
        S_DSEL,
        S_MX,
        S_MY,
        S_ROOT,
        S_ACC,
        S_PSAT,
        S_APPLY,
        S_RV0,
        S_RV1,
        S_RV2,
        S_RV3,
        S_TOUR,
        S_T0,
        S_TRD,
        S_TCAP,
        S_DONE
    } state_t;

    function automatic logic signed [DELTA_W-1:0] sat_delta(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = v;
            if (v > DELTA_MAX) r = DELTA_MAX;
            if (v < DELTA_MIN) r = DELTA_MIN;
            return DELTA_W'(r);
        end
    endfunction

    function automatic logic signed [ENERGY_W-1:0] sat_energy(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = v;
            if (v > ENERGY_MAX) r = ENERGY_MAX;
            if (v < ENERGY_MIN) r = ENERGY_MIN;
            return ENERGY_W'(r);
        end
    endfunction

endpackage

@@ rtl/tom_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/two_opt_tour_move_engine.sv @@
// 2-opt move engine: city store, proposal delta, segment reversal, tour length.
// Depends on tom_pkg and tom_ram.
// One item is taken at a time; s_ready is high only while the sequencer is idle.
// Load writes one city into the store if its index is in range. A proposal reads four
// cities and runs four distances through one shared multiplier and a one-digit-per-cycle
// square root. Apply swaps the segment ends pair by pair through the single store read
// port. Tour length sums the distances between consecutive cities, closing at city 0.
// A finished result sits in the output register while the next item may be taken.
module two_opt_tour_move_engine
    import tom_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [COUNT_W-1:0]           cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_mode,
    input  logic [INDEX_W-1:0]           s_index_a,
    input  logic [INDEX_W-1:0]           s_index_b,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [DELTA_W-1:0]    s_move_delta,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [INDEX_W-1:0]           m_first_index,
    output logic [INDEX_W-1:0]           m_second_index,
    output logic signed [DELTA_W-1:0]    m_delta,
    output logic signed [ENERGY_W-1:0]   m_energy
);

    localparam int IDX_W  = $clog2(MAX_CITIES);
    localparam int CMP_W  = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam int DX_W   = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DX_W;
    localparam int D      = COORD_BITS + 1 + FRAC_BITS;
    localparam int R      = SQ_W + 2 * FRAC_BITS;
    localparam int ACC_W  = D + 3;
    localparam int TS_W   = D + IDX_W + 2;
    localparam int RC_W   = $clog2(D);
    localparam int CITY_W = 2 * COORD_BITS;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]           count_reg;
    logic                         m_valid_reg, m_valid_next;
    logic signed [ENERGY_W-1:0]   energy_reg, energy_next;

    logic [1:0]                   mode_reg, mode_next;
    logic [INDEX_W-1:0]           ia_reg, ia_next, ib_reg, ib_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [DELTA_W-1:0]    md_reg, md_next;

    logic [IDX_W-1:0] a_idx_reg, a_idx_next, b_idx_reg, b_idx_next;
    logic [IDX_W-1:0] pa_idx_reg, pa_idx_next, nb_idx_reg, nb_idx_next;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CMP_W-1:0] i_reg, i_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       k_reg, k_next;

    logic signed [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [COORD_BITS-1:0] pax_reg, pax_next, pay_reg, pay_next;
    logic signed [COORD_BITS-1:0] nbx_reg, nbx_next, nby_reg, nby_next;
    logic [CITY_W-1:0]            tmp_reg, tmp_next;

    logic signed [DX_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [R-1:0]           rad_reg, rad_next;
    logic [D+1:0]           rem_reg, rem_next;
    logic [D-1:0]           root_reg, root_next;
    logic [RC_W-1:0]        rc_reg, rc_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [TS_W-1:0]  ts_reg, ts_next;

    logic [INDEX_W-1:0]         rf_reg, rf_next, rs_reg, rs_next;
    logic signed [DELTA_W-1:0]  rd_reg, rd_next;
    logic [INDEX_W-1:0]         of_reg, os_reg;
    logic signed [DELTA_W-1:0]  od_reg;
    logic signed [ENERGY_W-1:0] oe_reg;
    logic                       out_load;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [CITY_W-1:0] ram_wdata, ram_rdata;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;

    logic [CMP_W-1:0] n_w, ia_w, ib_w, a0, b0, pa_w, nb_w, lo_w, hi_w;
    logic [CMP_W-1:0] pa_c, nb_c;
    logic             whole;

    logic signed [COORD_BITS-1:0] spx, spy, sqx, sqy;
    logic signed [DX_W-1:0]       mul_in;
    logic signed [SQ_W-1:0]       prod;
    logic [SQ_W-1:0]              sq_sum;
    logic [D+1:0]                 rem_sh, trial;
    logic                         ge;
    logic signed [ACC_W-1:0]      root_s;

    tom_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[CITY_W-1:COORD_BITS];
    assign rd_y = ram_rdata[COORD_BITS-1:0];

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_first_index  = of_reg;
    assign m_second_index = os_reg;
    assign m_delta        = od_reg;
    assign m_energy       = oe_reg;

    // effective count and ordered proposal indices
    always_comb begin
        n_w  = (CMP_W'(count_reg) > CMP_W'(MAX_CITIES)) ? CMP_W'(MAX_CITIES)
                                                        : CMP_W'(count_reg);
        ia_w = CMP_W'(ia_reg);
        ib_w = CMP_W'(ib_reg);
        a0   = (ia_w > n_w - 1'b1) ? n_w - 1'b1 : ia_w;
        b0   = (ib_w > n_w - 2'd2) ? n_w - 2'd2 : ib_w;
        if (b0 >= a0) begin
            pa_w = a0;
            nb_w = b0 + 1'b1;
        end else begin
            pa_w = b0;
            nb_w = a0;
        end
        whole = (pa_w == '0) && (nb_w == n_w - 1'b1);
        pa_c  = (pa_w == '0) ? n_w - 1'b1 : pa_w - 1'b1;
        nb_c  = (nb_w == n_w - 1'b1) ? '0 : nb_w + 1'b1;
        lo_w  = (ia_w < ib_w) ? ia_w : ib_w;
        hi_w  = (ia_w < ib_w) ? ib_w : ia_w;
    end

    // distance operand select
    always_comb begin
        spx = ax_reg;
        spy = ay_reg;
        sqx = bx_reg;
        sqy = by_reg;
        if (mode_reg == MODE_PROPOSE) begin
            case (k_reg)
                2'd0: begin
                    spx = ax_reg; spy = ay_reg; sqx = nbx_reg; sqy = nby_reg;
                end
                2'd1: begin
                    spx = bx_reg; spy = by_reg; sqx = pax_reg; sqy = pay_reg;
                end
                2'd2: begin
                    spx = ax_reg; spy = ay_reg; sqx = pax_reg; sqy = pay_reg;
                end
                default: begin
                    spx = bx_reg; spy = by_reg; sqx = nbx_reg; sqy = nby_reg;
                end
            endcase
        end
    end

    // shared multiplier and square-root step
    always_comb begin
        mul_in = (state_reg == S_MX) ? dx_reg : dy_reg;
        prod   = mul_in * mul_in;
        sq_sum = sq_reg + $unsigned(prod);
        rem_sh = {rem_reg[D-1:0], rad_reg[R-1 -: 2]};
        trial  = {root_reg, 2'b01};
        ge     = (rem_sh >= trial);
        root_s = $signed(ACC_W'(root_reg));
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        energy_next  = energy_reg;
        mode_next = mode_reg;  ia_next = ia_reg;  ib_next = ib_reg;
        x_next = x_reg;  y_next = y_reg;  md_next = md_reg;
        a_idx_next = a_idx_reg;  b_idx_next = b_idx_reg;
        pa_idx_next = pa_idx_reg;  nb_idx_next = nb_idx_reg;
        lo_next = lo_reg;  hi_next = hi_reg;  i_next = i_reg;
        cnt_next = cnt_reg;  k_next = k_reg;
        ax_next = ax_reg;  ay_next = ay_reg;  bx_next = bx_reg;  by_next = by_reg;
        pax_next = pax_reg;  pay_next = pay_reg;  nbx_next = nbx_reg;  nby_next = nby_reg;
        tmp_next = tmp_reg;
        dx_next = dx_reg;  dy_next = dy_reg;  sq_next = sq_reg;  rad_next = rad_reg;
        rem_next = rem_reg;  root_next = root_reg;  rc_next = rc_reg;
        acc_next = acc_reg;  ts_next = ts_reg;
        rf_next = rf_reg;  rs_next = rs_reg;  rd_next = rd_reg;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(ia_reg);
        ram_wdata = {x_reg, y_reg};
        ram_raddr = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    ia_next   = s_index_a;
                    ib_next   = s_index_b;
                    x_next    = s_coord_x;
                    y_next    = s_coord_y;
                    md_next   = s_move_delta;
                    rf_next   = '0;
                    rs_next   = '0;
                    rd_next   = '0;
                    case (s_mode)
                        MODE_LOAD:    state_next = S_LOAD;
                        MODE_PROPOSE: state_next = S_PREP;
                        MODE_APPLY:   state_next = S_APPLY;
                        default:      state_next = S_TOUR;
                    endcase
                end
            end
            S_LOAD: begin
                ram_we     = (CMP_W'(ia_reg) < CMP_W'(MAX_CITIES));
                rf_next    = ia_reg;
                state_next = S_DONE;
            end
            S_PREP: begin
                if (n_w < CMP_W'(2)) begin
                    state_next = S_DONE;
                end else begin
                    rf_next     = INDEX_W'(pa_w);
                    rs_next     = INDEX_W'(nb_w);
                    a_idx_next  = IDX_W'(pa_w);
                    b_idx_next  = IDX_W'(nb_w);
                    pa_idx_next = IDX_W'(pa_c);
                    nb_idx_next = IDX_W'(nb_c);
                    cnt_next    = '0;
                    k_next      = '0;
                    acc_next    = '0;
                    state_next  = whole ? S_DONE : S_PRD;
                end
            end
            S_PRD: begin
                case (cnt_reg)
                    3'd0: ram_raddr = a_idx_reg;
                    3'd1: ram_raddr = b_idx_reg;
                    3'd2: ram_raddr = pa_idx_reg;
                    default: ram_raddr = nb_idx_reg;
                endcase
                case (cnt_reg)
                    3'd1: begin ax_next = rd_x;  ay_next = rd_y;  end
                    3'd2: begin bx_next = rd_x;  by_next = rd_y;  end
                    3'd3: begin pax_next = rd_x; pay_next = rd_y; end
                    3'd4: begin nbx_next = rd_x; nby_next = rd_y; end
                    default: ;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd4) begin
                    state_next = S_DSEL;
                end
            end
            S_DSEL: begin
                dx_next    = DX_W'(spx) - DX_W'(sqx);
                dy_next    = DX_W'(spy) - DX_W'(sqy);
                state_next = S_MX;
            end
            S_MX: begin
                sq_next    = $unsigned(prod);
                state_next = S_MY;
            end
            S_MY: begin
                rad_next   = R'(sq_sum) << (2 * FRAC_BITS);
                rem_next   = '0;
                root_next  = '0;
                rc_next    = '0;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                rem_next  = ge ? rem_sh - trial : rem_sh;
                root_next = {root_reg[D-2:0], ge};
                rad_next  = rad_reg << 2;
                rc_next   = rc_reg + 1'b1;
                if (rc_reg == RC_W'(D - 1)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                if (mode_reg == MODE_PROPOSE) begin
                    acc_next = k_reg[1] ? acc_reg - root_s : acc_reg + root_s;
                    k_next   = k_reg + 1'b1;
                    state_next = (k_reg == 2'd3) ? S_PSAT : S_DSEL;
                end else begin
                    ts_next = ts_reg + $signed(TS_W'(root_reg));
                    ax_next = bx_reg;
                    ay_next = by_reg;
                    i_next  = i_reg + 1'b1;
                    if (i_reg == n_w - 1'b1) begin
                        energy_next = sat_energy(64'(ts_reg + $signed(TS_W'(root_reg))));
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_TRD;
                    end
                end
            end
            S_PSAT: begin
                rd_next    = sat_delta(64'(acc_reg));
                state_next = S_DONE;
            end
            S_APPLY: begin
                energy_next = sat_energy(64'(energy_reg) + 64'(md_reg));
                rf_next     = INDEX_W'(lo_w);
                rs_next     = INDEX_W'(hi_w);
                rd_next     = md_reg;
                lo_next     = IDX_W'(lo_w);
                hi_next     = IDX_W'(hi_w);
                state_next  = (hi_w < n_w) ? S_RV0 : S_DONE;
            end
            S_RV0: begin
                ram_raddr  = lo_reg;
                state_next = (lo_reg < hi_reg) ? S_RV1 : S_DONE;
            end
            S_RV1: begin
                tmp_next   = ram_rdata;
                ram_raddr  = hi_reg;
                state_next = S_RV2;
            end
            S_RV2: begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = S_RV3;
            end
            S_RV3: begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = tmp_reg;
                lo_next    = lo_reg + 1'b1;
                hi_next    = hi_reg - 1'b1;
                state_next = S_RV0;
            end
            S_TOUR: begin
                ts_next = '0;
                i_next  = '0;
                if (n_w < CMP_W'(2)) begin
                    energy_next = '0;
                    state_next  = S_DONE;
                end else begin
                    ram_raddr  = '0;
                    state_next = S_T0;
                end
            end
            S_T0: begin
                ax_next    = rd_x;
                ay_next    = rd_y;
                state_next = S_TRD;
            end
            S_TRD: begin
                ram_raddr  = (i_reg == n_w - 1'b1) ? '0 : IDX_W'(i_reg + 1'b1);
                state_next = S_TCAP;
            end
            S_TCAP: begin
                bx_next    = rd_x;
                by_next    = rd_y;
                state_next = S_DSEL;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            energy_reg  <= '0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            energy_reg  <= energy_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;  ia_reg <= ia_next;  ib_reg <= ib_next;
        x_reg <= x_next;  y_reg <= y_next;  md_reg <= md_next;
        a_idx_reg <= a_idx_next;  b_idx_reg <= b_idx_next;
        pa_idx_reg <= pa_idx_next;  nb_idx_reg <= nb_idx_next;
        lo_reg <= lo_next;  hi_reg <= hi_next;  i_reg <= i_next;
        cnt_reg <= cnt_next;  k_reg <= k_next;
        ax_reg <= ax_next;  ay_reg <= ay_next;  bx_reg <= bx_next;  by_reg <= by_next;
        pax_reg <= pax_next;  pay_reg <= pay_next;
        nbx_reg <= nbx_next;  nby_reg <= nby_next;
        tmp_reg <= tmp_next;
        dx_reg <= dx_next;  dy_reg <= dy_next;  sq_reg <= sq_next;  rad_reg <= rad_next;
        rem_reg <= rem_next;  root_reg <= root_next;  rc_reg <= rc_next;
        acc_reg <= acc_next;  ts_reg <= ts_next;
        rf_reg <= rf_next;  rs_reg <= rs_next;  rd_reg <= rd_next;
        if (out_load) begin
            of_reg <= rf_reg;
            os_reg <= rs_reg;
            od_reg <= rd_reg;
            oe_reg <= energy_reg;
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("sequencer idle right after an input transfer");

    a_root_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROOT |-> rc_reg < RC_W'(D))
        else $error("square-root digit counter out of range");

    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RV1 |-> lo_reg < hi_reg)
        else $error("segment swap with crossed indices");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done step");
`endif

endmodule

@@ sim/move_result_checker.sv @@
// Checker for the 2-opt tour move engine: watches both channels and config writes,
// predicts each result from its own tour store and energy, and counts mismatches.
// Depends on tom_pkg.
module move_result_checker
    import tom_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [COUNT_W-1:0]         cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_mode,
    input  logic [INDEX_W-1:0]         s_index_a,
    input  logic [INDEX_W-1:0]         s_index_b,
    input  logic signed [15:0]         s_coord_x,
    input  logic signed [15:0]         s_coord_y,
    input  logic signed [DELTA_W-1:0]  s_move_delta,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [INDEX_W-1:0]         m_first_index,
    input  logic [INDEX_W-1:0]         m_second_index,
    input  logic signed [DELTA_W-1:0]  m_delta,
    input  logic signed [ENERGY_W-1:0] m_energy,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [INDEX_W-1:0]         first;
        logic [INDEX_W-1:0]         second;
        logic signed [DELTA_W-1:0]  delta;
        logic signed [ENERGY_W-1:0] energy;
    } move_result_t;

    logic signed [15:0] city_x [256];
    logic signed [15:0] city_y [256];
    longint             energy_acc;
    int                 city_cnt;
    move_result_t       expected_moves[$];

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // floor(sqrt(v)) bit by bit
    function automatic longint int_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint seg_length(input int i, input int j);
        longint dx;
        longint dy;
        dx = longint'(city_x[i]) - longint'(city_x[j]);
        dy = longint'(city_y[i]) - longint'(city_y[j]);
        return int_root(64'(dx * dx + dy * dy) << 16);
    endfunction

    function automatic move_result_t predict_item(input logic [1:0] mode,
            input int ia, input int ib, input logic signed [15:0] x,
            input logic signed [15:0] y, input logic signed [DELTA_W-1:0] md);
        move_result_t r;
        int n, a, b, t, pa, nb, lo, hi;
        longint d, sum;
        logic signed [15:0] tx, ty;
        n = city_cnt > 256 ? 256 : city_cnt;
        r = '0;
        d = 0;
        case (mode)
            MODE_LOAD: begin
                city_x[ia] = x;
                city_y[ia] = y;
                r.first = ia;
            end
            MODE_PROPOSE: begin
                if (n >= 2) begin
                    a = ia > n - 1 ? n - 1 : ia;
                    b = ib > n - 2 ? n - 2 : ib;
                    if (b >= a) begin
                        b++;
                    end else begin
                        t = a; a = b; b = t;
                    end
                    r.first = a;
                    r.second = b;
                    if (!(a == 0 && b == n - 1)) begin
                        pa = a == 0 ? n - 1 : a - 1;
                        nb = b == n - 1 ? 0 : b + 1;
                        d = seg_length(a, nb) + seg_length(b, pa)
                            - seg_length(a, pa) - seg_length(b, nb);
                        d = clamp(d, DELTA_W);
                    end
                end
            end
            MODE_APPLY: begin
                lo = ia < ib ? ia : ib;
                hi = ia < ib ? ib : ia;
                d = md;
                energy_acc = clamp(energy_acc + d, ENERGY_W);
                r.first = lo;
                r.second = hi;
                if (hi < n) begin
                    while (lo < hi) begin
                        tx = city_x[lo]; ty = city_y[lo];
                        city_x[lo] = city_x[hi]; city_y[lo] = city_y[hi];
                        city_x[hi] = tx; city_y[hi] = ty;
                        lo++; hi--;
                    end
                end
            end
            default: begin
                sum = 0;
                if (n >= 2)
                    for (int i = 0; i < n; i++) sum += seg_length(i, i == n - 1 ? 0 : i + 1);
                energy_acc = clamp(sum, ENERGY_W);
            end
        endcase
        r.delta = DELTA_W'(d);
        r.energy = ENERGY_W'(energy_acc);
        return r;
    endfunction

    assign pending = expected_moves.size();

    always @(posedge aclk) begin
        move_result_t got, want;
        if (!aresetn) begin
            energy_acc = 0;
            city_cnt = 0;
            fail_count = 0;
            expected_moves.delete();
        end else begin
            if (cfg_wr_en) city_cnt = cfg_wr_data;
            if (m_valid && m_ready) begin
                got = '{m_first_index, m_second_index, m_delta, m_energy};
                if (expected_moves.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected transfer: first %0d second %0d delta %0d energy %0d",
                             $time, got.first, got.second, got.delta, got.energy);
                end else begin
                    want = expected_moves.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display("%0t expected first %0d second %0d delta %0d energy %0d",
                                 $time, want.first, want.second, want.delta, want.energy);
                        $display("%0t actual   first %0d second %0d delta %0d energy %0d",
                                 $time, got.first, got.second, got.delta, got.energy);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_moves.push_back(predict_item(s_mode, s_index_a, s_index_b,
                                                      s_coord_x, s_coord_y, s_move_delta));
        end
    end
endmodule

@@ sim/tb_two_opt_tour_move_engine.sv @@
// Testbench top for the 2-opt tour move engine: clock, reset, stimulus and verdict.
// Depends on tom_pkg, the engine RTL and move_result_checker.
module tb_two_opt_tour_move_engine;
    import tom_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]         cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_mode = MODE_LOAD;
    logic [INDEX_W-1:0]         s_index_a = '0;
    logic [INDEX_W-1:0]         s_index_b = '0;
    logic signed [15:0]         s_coord_x = '0;
    logic signed [15:0]         s_coord_y = '0;
    logic signed [DELTA_W-1:0]  s_move_delta = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [INDEX_W-1:0]         m_first_index;
    logic [INDEX_W-1:0]         m_second_index;
    logic signed [DELTA_W-1:0]  m_delta;
    logic signed [ENERGY_W-1:0] m_energy;
    int                         fail_count;
    int                         pending;
    int                         cycles = 0;
    bit                         long_hold = 0;
    int                         city_n = 0;

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    two_opt_tour_move_engine dut (.*);

    move_result_checker chk (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 10000000) begin
            $display("two_opt_tour_move_engine: mismatch");
            $finish;
        end
    end

    // receiver: short and long stalls, one forced long hold-off
    initial begin
        int len;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            if (long_hold) begin
                len = 400;
                long_hold = 0;
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
            end
            if (len > 0) begin
                m_ready = 1'b0;
                repeat (len - 1) @(negedge aclk);
            end
        end
    end

    task automatic send(input logic [1:0] mode, input int a, input int b,
                        input logic signed [15:0] x, input logic signed [15:0] y,
                        input logic signed [DELTA_W-1:0] d);
        int r;
        s_mode = mode;
        s_index_a = a;
        s_index_b = b;
        s_coord_x = x;
        s_coord_y = y;
        s_move_delta = d;
        s_valid = 1'b1;
        while (!s_ready) @(negedge aclk);
        @(negedge aclk);
        r = $urandom_range(0, 15);
        if (r >= 10) begin
            s_valid = 1'b0;
            repeat (r < 15 ? $urandom_range(1, 4) : $urandom_range(10, 60)) @(negedge aclk);
        end
    endtask

    task automatic drain_and_set(input int cnt);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = cnt;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        city_n = cnt;
    endtask

    function automatic int pick_index(input int n);
        if (n == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic random_item();
        int r, n;
        logic signed [DELTA_W-1:0] d;
        n = city_n > 256 ? 256 : city_n;
        r = $urandom_range(0, 99);
        d = $urandom_range(0, 3) == 0 ? DELTA_W'($urandom) : DELTA_W'($signed($urandom_range(0, 8191)) - 4096);
        if (r < 15)
            send(MODE_LOAD, $urandom_range(0, 255), 0, 16'($urandom), 16'($urandom), d);
        else if (r < 60)
            send(MODE_PROPOSE, pick_index(n), n > 1 ? pick_index(n - 1) : pick_index(0),
                 16'($urandom), 16'($urandom), d);
        else if (r < 95 || (n > 64 && r < 98))
            send(MODE_APPLY, pick_index(n), pick_index(n), 16'($urandom), 16'($urandom), d);
        else
            send(MODE_TOUR, $urandom_range(0, 255), $urandom_range(0, 255),
                 16'($urandom), 16'($urandom), d);
    endtask

    initial begin
        int counts[8];
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // every slot written before any read
        drain_and_set(0);
        send(MODE_LOAD, 0, 0, -16'sd32768, -16'sd32768, '0);
        send(MODE_LOAD, 1, 0, 16'sd32767, 16'sd32767, '0);
        send(MODE_LOAD, 2, 0, 16'sd32767, -16'sd32768, '0);
        for (int i = 3; i < 256; i++)
            send(MODE_LOAD, i, 255, 16'($urandom), 16'($urandom), DELTA_W'($urandom));
        send(MODE_PROPOSE, 0, 0, '0, '0, '0);
        send(MODE_TOUR, 0, 0, '0, '0, '0);
        send(MODE_APPLY, 0, 1, '0, '0, 27'sh3ffffff);
        drain_and_set(1);
        send(MODE_PROPOSE, 0, 0, '0, '0, '0);
        send(MODE_TOUR, 0, 0, '0, '0, '0);
        send(MODE_APPLY, 0, 0, '0, '0, 27'sh4000000);
        drain_and_set(2);
        send(MODE_PROPOSE, 0, 0, '0, '0, '0);
        send(MODE_PROPOSE, 255, 255, '0, '0, '0);
        send(MODE_TOUR, 0, 0, '0, '0, '0);
        send(MODE_APPLY, 1, 0, '0, '0, -27'sd5);
        drain_and_set(3);
        send(MODE_PROPOSE, 0, 1, '0, '0, '0);
        send(MODE_PROPOSE, 2, 0, '0, '0, '0);
        send(MODE_APPLY, 0, 2, '0, '0, 27'sd100);
        send(MODE_TOUR, 0, 0, '0, '0, '0);
        drain_and_set(256);
        send(MODE_PROPOSE, 255, 255, '0, '0, '0);
        send(MODE_PROPOSE, 0, 254, '0, '0, '0);
        send(MODE_PROPOSE, 128, 3, '0, '0, '0);
        send(MODE_APPLY, 255, 0, '0, '0, 27'sh3ffffff);
        send(MODE_APPLY, 10, 250, '0, '0, 27'sh4000000);
        send(MODE_TOUR, 0, 0, '0, '0, '0);

        // fill the block while the receiver holds off
        long_hold = 1;
        for (int i = 0; i < 6; i++) begin
            s_mode = MODE_PROPOSE;
            s_index_a = INDEX_W'($urandom);
            s_index_b = INDEX_W'($urandom);
            s_valid = 1'b1;
            while (!s_ready) @(negedge aclk);
            @(negedge aclk);
        end
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);

        counts = '{2, 256, 3, 0, 1, 7, 16, 40};
        counts[5] = $urandom_range(4, 255);
        counts[7] = $urandom_range(2, 64);
        foreach (counts[p]) begin
            drain_and_set(counts[p]);
            repeat (75) random_item();
        end

        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("two_opt_tour_move_engine: match");
        else
            $display("two_opt_tour_move_engine: mismatch");
        $finish;
    end
endmodule

@@ two_opt_tour_move_engine.f @@
rtl/tom_pkg.sv
rtl/tom_ram.sv
rtl/two_opt_tour_move_engine.sv
sim/move_result_checker.sv
sim/tb_two_opt_tour_move_engine.sv
